@@ design/ket_pkg.sv @@
package ket_pkg;

  localparam int KET_ENTRIES   = 64;
  localparam int KET_KEY_BITS  = 32;
  localparam int KET_TIME_BITS = 48;

  localparam int ACTION_W = 4;
  localparam int KEY_ID_W = 32;
  localparam int TTL_W    = 32;
  localparam int VALUE_W  = 49;
  localparam int STATUS_W = 2;
  localparam int USED_W   = 7;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SET      = 4'd0,
    ACT_TTL      = 4'd1,
    ACT_EXPIRY   = 4'd2,
    ACT_PERSIST  = 4'd3,
    ACT_REMOVE   = 4'd4,
    ACT_EXPIRED  = 4'd5,
    ACT_CONTAINS = 4'd6,
    ACT_SWEEP    = 4'd7,
    ACT_TICK     = 4'd8,
    ACT_CLEAR    = 4'd9
  } ket_action_t;

  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_ZERO_TTL = 2'd2;

  // Two's complement -2 and -1 at the result width.
  localparam logic [VALUE_W-1:0] VAL_NO_TTL    = {{(VALUE_W-1){1'b1}}, 1'b0};
  localparam logic [VALUE_W-1:0] VAL_NO_EXPIRY = {VALUE_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } ket_state_t;

  // Outcome of comparing a stored expiry time against the clock.
  typedef struct packed {
    logic expired;
    logic live;
  } ket_cmp_t;

endpackage

@@ design/ket_store.sv @@
module ket_store #(
  parameter int ENTRIES   = 64,
  parameter int KEY_BITS  = 32,
  parameter int TIME_BITS = 48,
  localparam int IW = $clog2(ENTRIES)
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [IW-1:0]        rd_idx,
  output logic [KEY_BITS-1:0]  rd_key,
  output logic [TIME_BITS-1:0] rd_exp,
  input  logic                 wr_en,
  input  logic [IW-1:0]        wr_idx,
  input  logic [KEY_BITS-1:0]  wr_key,
  input  logic [TIME_BITS-1:0] wr_exp
);

  logic [KEY_BITS-1:0]  key_mem [ENTRIES];
  logic [TIME_BITS-1:0] exp_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_idx] <= wr_key;
      exp_mem[wr_idx] <= wr_exp;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key <= key_mem[rd_idx];
      rd_exp <= exp_mem[rd_idx];
    end
  end

endmodule

@@ design/ket_time_unit.sv @@
module ket_time_unit
  import ket_pkg::*;
#(
  parameter int TIME_BITS = 48
) (
  input  logic [TIME_BITS-1:0] expiry,
  input  logic [TIME_BITS-1:0] now,
  output logic [TIME_BITS-1:0] remain,
  output ket_cmp_t             cmp
);

  logic [TIME_BITS:0] diff;

  // A borrow or a zero difference means the clock has reached the expiry time.
  assign diff        = {1'b0, expiry} - {1'b0, now};
  assign remain      = diff[TIME_BITS-1:0];
  assign cmp.expired = diff[TIME_BITS] | (diff[TIME_BITS-1:0] == '0);
  assign cmp.live    = ~cmp.expired;

endmodule

@@ design/key_expiry_table.sv @@
// Channel  Direction  Ports                                              Handshake
// in       input      in_action, in_key_id, in_ttl_ms                    in_valid / in_stall
// out      output     out_value, out_flag, out_status, out_entries_used  out_valid / out_stall
//
// Set, ttl, expiry, persist, remove, expired, contains and sweep scan the whole table
// through one read port before they finish; a new item is accepted only after the last has finished.
// Tick, clear, unknown actions and set with zero ttl skip the scan and go straight to finish.
// A synchronous reset empties the table at once through the valid bits; the clock reads 0.
// A result waits in the output register while out_stall is high; the next item is
// accepted meanwhile, but its result is held until the register is free.
module key_expiry_table
  import ket_pkg::*;
#(
  parameter int ENTRIES   = KET_ENTRIES,
  parameter int KEY_BITS  = KET_KEY_BITS,
  parameter int TIME_BITS = KET_TIME_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ACTION_W-1:0]        in_action,
  input  logic [KEY_ID_W-1:0]        in_key_id,
  input  logic [TTL_W-1:0]           in_ttl_ms,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [VALUE_W-1:0]  out_value,
  output logic                       out_flag,
  output logic [STATUS_W-1:0]        out_status,
  output logic [USED_W-1:0]          out_entries_used
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  ket_state_t state_r, state_nxt;

  logic [ENTRIES-1:0]   valid_r, valid_nxt;
  logic [CW-1:0]        used_r, used_nxt;
  logic [TIME_BITS-1:0] now_r;

  logic [ACTION_W-1:0]  act_r;
  logic [KEY_BITS-1:0]  key_r;
  logic                 ttl_zero_r;
  logic [TIME_BITS-1:0] sum_r;

  logic [IW-1:0]        scan_idx_r;
  logic                 issue_done_r;
  logic                 rd_pend_r;
  logic [IW-1:0]        rd_idx_r;
  logic                 rd_vld_r;
  logic [KEY_BITS-1:0]  rd_key;
  logic [TIME_BITS-1:0] rd_exp;

  logic                 found_r;
  logic [IW-1:0]        slot_r;
  logic [TIME_BITS-1:0] hit_exp_r;
  logic [TIME_BITS-1:0] hit_remain_r;
  logic                 hit_expired_r;
  logic                 free_found_r;
  logic [IW-1:0]        free_slot_r;
  logic [CW-1:0]        sweep_cnt_r;

  logic                 out_valid_r;
  logic [VALUE_W-1:0]   out_value_r;
  logic                 out_flag_r;
  logic [STATUS_W-1:0]  out_status_r;

  logic                 in_acc;
  logic                 rd_en;
  logic                 cmp_en;
  logic                 fin_go;
  logic                 hit;
  logic                 sweep_hit;
  logic [TIME_BITS-1:0] remain;
  ket_cmp_t             cmp;

  logic [KEY_BITS+KEY_ID_W-1:0] key_wide;
  logic [KEY_BITS-1:0]          key_in;
  logic [TIME_BITS:0]           sum_full;
  logic [TIME_BITS-1:0]         sum_sat;

  logic                 wr_en;
  logic [IW-1:0]        wr_idx;
  logic                 set_new;
  logic                 del_hit;
  logic                 clr_all;
  logic [VALUE_W-1:0]   res_value;
  logic                 res_flag;
  logic [STATUS_W-1:0]  res_status;

  // Only the low KEY_BITS bits of the identifier take part in a match.
  assign key_wide = {{KEY_BITS{1'b0}}, in_key_id};
  assign key_in   = key_wide[KEY_BITS-1:0];

  assign sum_full = {1'b0, now_r} + (TIME_BITS + 1)'(in_ttl_ms);
  assign sum_sat  = sum_full[TIME_BITS] ? {TIME_BITS{1'b1}} : sum_full[TIME_BITS-1:0];

  assign in_acc = in_valid && !in_stall;

  ket_store #(
    .ENTRIES   (ENTRIES),
    .KEY_BITS  (KEY_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_store (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_idx (scan_idx_r),
    .rd_key (rd_key),
    .rd_exp (rd_exp),
    .wr_en  (wr_en),
    .wr_idx (wr_idx),
    .wr_key (key_r),
    .wr_exp (sum_r)
  );

  ket_time_unit #(
    .TIME_BITS (TIME_BITS)
  ) u_time (
    .expiry (rd_exp),
    .now    (now_r),
    .remain (remain),
    .cmp    (cmp)
  );

  assign hit       = rd_vld_r && (rd_key == key_r);
  assign sweep_hit = (act_r == ACT_SWEEP) && rd_vld_r && cmp.expired;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_action) inside
            ACT_SET:
              state_nxt = (in_ttl_ms == '0) ? ST_FINISH : ST_SCAN;
            ACT_TTL, ACT_EXPIRY, ACT_PERSIST, ACT_REMOVE, ACT_EXPIRED, ACT_CONTAINS,
            ACT_SWEEP:
              state_nxt = ST_SCAN;
            default:
              state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_SCAN: begin
        if (rd_pend_r && (rd_idx_r == LAST_IDX)) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (fin_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    fin_go   = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_stall = 1'b0;
      ST_SCAN:   rd_en    = !issue_done_r;
      ST_FINISH: fin_go   = !out_valid_r || !out_stall;
      default:   in_stall = 1'b1;
    endcase
  end

  assign cmp_en = rd_pend_r;

  // Result and table effects of the item being finished.
  always_comb begin
    res_value  = '0;
    res_flag   = 1'b0;
    res_status = STAT_OK;
    wr_en      = 1'b0;
    wr_idx     = slot_r;
    set_new    = 1'b0;
    del_hit    = 1'b0;
    clr_all    = 1'b0;
    unique case (act_r) inside
      ACT_SET: begin
        if (ttl_zero_r) begin
          res_status = STAT_ZERO_TTL;
        end else if (found_r) begin
          wr_en     = fin_go;
          res_value = VALUE_W'(sum_r);
        end else if (free_found_r) begin
          wr_en     = fin_go;
          wr_idx    = free_slot_r;
          set_new   = 1'b1;
          res_value = VALUE_W'(sum_r);
        end else begin
          res_status = STAT_FULL;
        end
      end
      ACT_TTL: begin
        res_value = (found_r && !hit_expired_r) ? VALUE_W'(hit_remain_r) : VAL_NO_TTL;
      end
      ACT_EXPIRY: begin
        res_value = found_r ? VALUE_W'(hit_exp_r) : VAL_NO_EXPIRY;
      end
      ACT_PERSIST: begin
        del_hit  = found_r;
        res_flag = found_r;
      end
      ACT_REMOVE:   del_hit   = found_r;
      ACT_EXPIRED:  res_flag  = found_r && hit_expired_r;
      ACT_CONTAINS: res_flag  = found_r;
      ACT_SWEEP:    res_value = VALUE_W'(sweep_cnt_r);
      ACT_CLEAR:    clr_all   = 1'b1;
      default:      res_value = '0;
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    used_nxt  = used_r;
    if (cmp_en && sweep_hit) begin
      valid_nxt[rd_idx_r] = 1'b0;
    end
    if (fin_go) begin
      if (set_new) begin
        valid_nxt[free_slot_r] = 1'b1;
        used_nxt               = used_r + CW'(1);
      end
      if (del_hit) begin
        valid_nxt[slot_r] = 1'b0;
        used_nxt          = used_r - CW'(1);
      end
      if (act_r == ACT_SWEEP) begin
        used_nxt = used_r - sweep_cnt_r;
      end
      if (clr_all) begin
        valid_nxt = '0;
        used_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      used_r       <= '0;
      now_r        <= '0;
      issue_done_r <= 1'b0;
      rd_pend_r    <= 1'b0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      sweep_cnt_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      used_r    <= used_nxt;
      rd_pend_r <= rd_en;
      if (in_acc) begin
        issue_done_r <= 1'b0;
        found_r      <= 1'b0;
        free_found_r <= 1'b0;
        sweep_cnt_r  <= '0;
      end
      if (rd_en && (scan_idx_r == LAST_IDX)) begin
        issue_done_r <= 1'b1;
      end
      if (cmp_en) begin
        if (hit && !found_r) begin
          found_r <= 1'b1;
        end
        if (!rd_vld_r && !free_found_r) begin
          free_found_r <= 1'b1;
        end
        if (sweep_hit) begin
          sweep_cnt_r <= sweep_cnt_r + CW'(1);
        end
      end
      if (fin_go && (act_r == ACT_TICK)) begin
        now_r <= sum_r;
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item payload, scan address and captured lookup data.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r      <= in_action;
      key_r      <= key_in;
      ttl_zero_r <= (in_ttl_ms == '0);
      sum_r      <= sum_sat;
      scan_idx_r <= '0;
    end else if (rd_en && (scan_idx_r != LAST_IDX)) begin
      scan_idx_r <= scan_idx_r + IW'(1);
    end
    if (rd_en) begin
      rd_idx_r <= scan_idx_r;
      rd_vld_r <= valid_r[scan_idx_r];
    end
    if (cmp_en && hit && !found_r) begin
      slot_r        <= rd_idx_r;
      hit_exp_r     <= rd_exp;
      hit_remain_r  <= remain;
      hit_expired_r <= cmp.expired;
    end
    if (cmp_en && !rd_vld_r && !free_found_r) begin
      free_slot_r <= rd_idx_r;
    end
    if (fin_go) begin
      out_value_r  <= res_value;
      out_flag_r   <= res_flag;
      out_status_r <= res_status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_value        = out_value_r;
  assign out_flag         = out_flag_r;
  assign out_status       = out_status_r;
  assign out_entries_used = USED_W'(used_r);

  a_pend_in_scan : assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (state_r == ST_SCAN))
    else $error("read data pending outside of a scan");

  a_used_bound : assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(ENTRIES))
    else $error("used count above table size");

  a_used_matches : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> ($countones(valid_r) == int'(used_r)))
    else $error("used count disagrees with valid bits");

  a_finish_loads : assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("finished item did not reach the output register");

endmodule

@@ tb/ket_checker.sv @@
module ket_checker
  import ket_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [ACTION_W-1:0]       in_action,
  input  logic [KEY_ID_W-1:0]       in_key_id,
  input  logic [TTL_W-1:0]          in_ttl_ms,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic signed [VALUE_W-1:0] out_value,
  input  logic                      out_flag,
  input  logic [STATUS_W-1:0]       out_status,
  input  logic [USED_W-1:0]         out_entries_used,
  output int                        fail_count,
  output int                        pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic                flag;
    logic [STATUS_W-1:0] status;
    logic [USED_W-1:0]   used;
  } ket_reply_t;

  localparam logic [KET_TIME_BITS-1:0] CLOCK_MAX = '1;

  logic                     rec_live   [KET_ENTRIES];
  logic [KET_KEY_BITS-1:0]  rec_key    [KET_ENTRIES];
  logic [KET_TIME_BITS-1:0] rec_expiry [KET_ENTRIES];
  logic [KET_TIME_BITS-1:0] clock_ms;
  logic [USED_W-1:0]        live_count;
  ket_reply_t               replies_due[$];
  int                       errors = 0;

  function automatic logic [KET_TIME_BITS-1:0] clamp_add(input logic [KET_TIME_BITS-1:0] base,
                                                          input logic [TTL_W-1:0] step);
    logic [KET_TIME_BITS:0] sum;
    sum = {1'b0, base} + (KET_TIME_BITS + 1)'(step);
    return (sum > {1'b0, CLOCK_MAX}) ? CLOCK_MAX : sum[KET_TIME_BITS-1:0];
  endfunction

  function automatic int slot_of(input logic [KET_KEY_BITS-1:0] key);
    for (int i = 0; i < KET_ENTRIES; i++) begin
      if (rec_live[i] && rec_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic int first_free();
    for (int i = 0; i < KET_ENTRIES; i++) begin
      if (!rec_live[i]) return i;
    end
    return -1;
  endfunction

  // Applies one command to the local copy of the table and returns its reply.
  function automatic ket_reply_t apply_command(input logic [ACTION_W-1:0] act,
                                               input logic [KEY_ID_W-1:0] key_in,
                                               input logic [TTL_W-1:0]    ttl);
    ket_reply_t              r;
    int                      slot;
    logic [KET_KEY_BITS-1:0] key;
    r    = '0;
    key  = key_in[KET_KEY_BITS-1:0];
    slot = slot_of(key);
    case (act)
      ACT_SET: begin
        if (ttl == '0) begin
          r.status = STAT_ZERO_TTL;
        end else begin
          if (slot < 0) begin
            slot = first_free();
            if (slot >= 0) begin
              rec_live[slot] = 1'b1;
              rec_key[slot]  = key;
              live_count++;
            end
          end
          if (slot < 0) begin
            r.status = STAT_FULL;
          end else begin
            rec_expiry[slot] = clamp_add(clock_ms, ttl);
            r.value = VALUE_W'(rec_expiry[slot]);
          end
        end
      end
      ACT_TTL: begin
        r.value = VAL_NO_TTL;
        if (slot >= 0) begin
          if (rec_expiry[slot] > clock_ms) r.value = VALUE_W'(rec_expiry[slot] - clock_ms);
        end
      end
      ACT_EXPIRY: begin
        r.value = VAL_NO_EXPIRY;
        if (slot >= 0) r.value = VALUE_W'(rec_expiry[slot]);
      end
      ACT_PERSIST, ACT_REMOVE: begin
        if (slot >= 0) begin
          rec_live[slot] = 1'b0;
          live_count--;
          r.flag = (act == ACT_PERSIST);
        end
      end
      ACT_EXPIRED: begin
        if (slot >= 0) r.flag = (clock_ms >= rec_expiry[slot]);
      end
      ACT_CONTAINS: r.flag = (slot >= 0);
      ACT_SWEEP: begin
        for (int i = 0; i < KET_ENTRIES; i++) begin
          if (rec_live[i] && clock_ms >= rec_expiry[i]) begin
            rec_live[i] = 1'b0;
            live_count--;
            r.value += 1;
          end
        end
      end
      ACT_TICK: clock_ms = clamp_add(clock_ms, ttl);
      ACT_CLEAR: begin
        for (int i = 0; i < KET_ENTRIES; i++) rec_live[i] = 1'b0;
        live_count = '0;
      end
      default: ;
    endcase
    r.used = live_count;
    return r;
  endfunction

  task automatic check_field(input string what, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    ket_reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < KET_ENTRIES; i++) rec_live[i] = 1'b0;
      clock_ms   = '0;
      live_count = '0;
      replies_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected result: value %0d, flag %0b, status %0d, used %0d",
                   $time, out_value, out_flag, out_status, out_entries_used);
          errors++;
        end else begin
          want = replies_due.pop_front();
          check_field("value", $signed(want.value), out_value);
          check_field("flag", want.flag, out_flag);
          check_field("status", want.status, out_status);
          check_field("entries_used", want.used, out_entries_used);
        end
      end
      if (in_valid && !in_stall) begin
        replies_due = {replies_due, apply_command(in_action, in_key_id, in_ttl_ms)};
      end
    end
    fail_count    <= errors;
    pending_count <= replies_due.size();
  end

endmodule

@@ tb/tb_key_expiry_table.sv @@
module tb_key_expiry_table;
  timeunit 1ns;
  timeprecision 1ps;
  import ket_pkg::*;

  localparam int QUIET_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 2 * KET_ENTRIES + 20;
  localparam int POOL_SIZE    = 96;
  // A short run of full-size ticks that pushes the clock far ahead.
  localparam int RAMP_TICKS   = 16;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic [ACTION_W-1:0]       in_action = '0;
  logic [KEY_ID_W-1:0]       in_key_id = '0;
  logic [TTL_W-1:0]          in_ttl_ms = '0;
  logic                      out_stall = 1'b0;
  logic                      in_stall;
  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_value;
  logic                      out_flag;
  logic [STATUS_W-1:0]       out_status;
  logic [USED_W-1:0]         out_entries_used;

  int fail_count;
  int pending_count;
  int send_idle_pct = 14;
  int recv_idle_pct = 84;
  logic [KEY_ID_W-1:0] key_pool [POOL_SIZE];

  always #1 clk = ~clk;

  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  key_expiry_table u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_key_id        (in_key_id),
    .in_ttl_ms        (in_ttl_ms),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_value        (out_value),
    .out_flag         (out_flag),
    .out_status       (out_status),
    .out_entries_used (out_entries_used)
  );

  ket_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_key_id        (in_key_id),
    .in_ttl_ms        (in_ttl_ms),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_value        (out_value),
    .out_flag         (out_flag),
    .out_status       (out_status),
    .out_entries_used (out_entries_used),
    .fail_count       (fail_count),
    .pending_count    (pending_count)
  );

  task automatic put_item(input logic [ACTION_W-1:0] act, input logic [KEY_ID_W-1:0] key,
                          input logic [TTL_W-1:0] ttl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_key_id <= key;
    in_ttl_ms <= ttl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Most keys come from a pool larger than the table so hits, misses and a full
  // table all occur.
  function automatic logic [KEY_ID_W-1:0] pick_key();
    if ($urandom_range(9) == 0) return $urandom;
    return key_pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  function automatic logic [TTL_W-1:0] pick_ttl();
    int r;
    r = $urandom_range(99);
    if (r < 65) return $urandom_range(300, 1);
    if (r < 82) return $urandom;
    if (r < 90) return '0;
    return '1;
  endfunction

  function automatic logic [TTL_W-1:0] pick_step();
    int r;
    r = $urandom_range(99);
    if (r < 85) return $urandom_range(60);
    if (r < 95) return $urandom_range(2000);
    return $urandom;
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 28)      put_item(ACT_SET, pick_key(), pick_ttl());
    else if (r < 36) put_item(ACT_TTL, pick_key(), $urandom);
    else if (r < 43) put_item(ACT_EXPIRY, pick_key(), $urandom);
    else if (r < 48) put_item(ACT_PERSIST, pick_key(), $urandom);
    else if (r < 53) put_item(ACT_REMOVE, pick_key(), $urandom);
    else if (r < 60) put_item(ACT_EXPIRED, pick_key(), $urandom);
    else if (r < 68) put_item(ACT_CONTAINS, pick_key(), $urandom);
    else if (r < 74) put_item(ACT_SWEEP, $urandom, $urandom);
    else if (r < 91) put_item(ACT_TICK, $urandom, pick_step());
    else if (r < 93) put_item(ACT_CLEAR, $urandom, $urandom);
    else             put_item(ACTION_W'($urandom_range(15, 10)), $urandom, $urandom);
  endtask

  // Packs the table past its capacity so that later sets of new keys are refused.
  task automatic fill_table();
    put_item(ACT_CLEAR, $urandom, $urandom);
    for (int i = 0; i < 70; i++) put_item(ACT_SET, key_pool[i], $urandom_range(400, 1));
  endtask

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 100) fill_table();
      random_item();
    end
  endtask

  initial begin
    logic [KEY_ID_W-1:0] k;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    put_item(ACT_TTL, 32'h0000_0000, '0);
    put_item(ACT_EXPIRY, 32'h0000_0000, '0);
    put_item(ACT_SET, 32'h0000_0000, '0);
    put_item(ACT_SET, 32'h0000_0000, 32'd1);
    put_item(ACT_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put_item(ACT_SET, 32'hFFFF_FFFF, 32'd5);
    put_item(ACT_TTL, 32'hFFFF_FFFF, '0);
    put_item(ACT_EXPIRY, 32'hFFFF_FFFF, '0);
    put_item(ACT_CONTAINS, 32'h0000_0000, '0);
    put_item(ACT_TICK, '0, '0);
    put_item(ACT_EXPIRED, 32'h0000_0000, '0);
    put_item(ACT_TICK, '0, 32'd1);
    put_item(ACT_EXPIRED, 32'h0000_0000, '0);
    put_item(ACT_TTL, 32'h0000_0000, '0);
    put_item(ACT_EXPIRY, 32'h0000_0000, '0);
    put_item(ACT_SWEEP, '0, '0);
    put_item(ACT_PERSIST, 32'hFFFF_FFFF, '0);
    put_item(ACT_PERSIST, 32'hFFFF_FFFF, '0);
    put_item(ACT_SET, 32'h0000_1234, 32'd100);
    put_item(ACT_REMOVE, 32'h0000_1234, '0);
    put_item(ACT_REMOVE, 32'h0000_1234, '0);
    put_item(ACTION_W'(15), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put_item(ACT_SET, 32'h0000_A5A5, 32'd10);
    put_item(ACT_CLEAR, '0, '0);
    put_item(ACT_TICK, '0, 32'hFFFF_FFFF);

    random_phase(300);
    send_idle_pct = 84;
    recv_idle_pct = 14;
    random_phase(300);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(300);

    // Push the clock ahead in large steps, probing stored times along the way.
    for (int i = 0; i < RAMP_TICKS; i++) begin
      put_item(ACT_TICK, $urandom, 32'hFFFF_FFFF);
      if (i % 8 == 7) begin
        k = key_pool[$urandom_range(POOL_SIZE - 1)];
        put_item(ACT_SET, k, $urandom_range(1) ? 32'hFFFF_FFFF : $urandom);
        put_item(ACT_TTL, k, $urandom);
        put_item(ACT_EXPIRY, k, $urandom);
      end
    end
    k = $urandom;
    put_item(ACT_SET, k, 32'hFFFF_FFFF);
    put_item(ACT_TTL, k, '0);
    put_item(ACT_EXPIRED, k, '0);
    put_item(ACT_EXPIRY, k, '0);
    random_phase(40);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("** key_expiry_table: PASSED **");
    else $display("** key_expiry_table: FAILED **");
    $finish;
  end

  // Ends a hung run: counts cycles in which neither channel moves an item.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
    $display("** key_expiry_table: FAILED **");
    $finish;
  end

endmodule
